>>> sv/lqfs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the link quality failsafe scaler.
package lqfs_pkg;

    localparam int LQ_W      = 10;
    localparam int TMR_W     = 26;
    localparam int EL_W      = 20;
    localparam int SCL_W     = 16;
    localparam int Q_W       = 17;
    localparam int Q_FRAC    = 15;
    localparam int B_W       = 18;
    localparam int DIV_W     = 25;
    localparam int DEN_W     = 10;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [LQ_W-1:0]  FULL_QUALITY = 10'd1000;
    localparam logic [Q_W-1:0]   Q_ONE        = 17'd32768;
    localparam logic [TMR_W-1:0] TIMER_MAX    = {TMR_W{1'b1}};

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FAILSAFE_LEVEL,
        REG_ENTER_DELAY,
        REG_RECOVER_LEVEL,
        REG_DEGRADED_LEVEL,
        REG_CRITICAL_LEVEL,
        REG_MINIMUM_SCALE,
        REG_CRITICAL_SCALE
    } t_reg_idx;

    typedef struct packed {
        logic [LQ_W-1:0]  failsafe_level;
        logic [TMR_W-1:0] enter_delay_us;
        logic [LQ_W-1:0]  recover_level;
        logic [LQ_W-1:0]  degraded_level;
        logic [LQ_W-1:0]  critical_level;
        logic [SCL_W-1:0] minimum_scale;
        logic [SCL_W-1:0] critical_scale;
    } t_cfg;

    typedef enum logic {
        MDU_MUL,
        MDU_DIV
    } t_mdu_op;

    typedef struct packed {
        logic    start;
        t_mdu_op op;
    } t_mdu_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mdu_sts;

endpackage

>>> sv/lqfs_in_if.sv
`timescale 1ns / 1ps
// Input channel: link report and stick beat.
interface lqfs_in_if #(
    parameter int AXIS_WIDTH = 16
);
    logic                               valid;
    logic                               ready;
    logic [lqfs_pkg::LQ_W-1:0]          link_quality;
    logic                               link_valid;
    logic [lqfs_pkg::EL_W-1:0]          elapsed_us;
    logic [AXIS_WIDTH-2:0]              throttle_in;
    logic signed [AXIS_WIDTH-1:0]       pitch_in;
    logic signed [AXIS_WIDTH-1:0]       roll_in;
    logic signed [AXIS_WIDTH-1:0]       yaw_in;

    modport source (
        output valid, link_quality, link_valid, elapsed_us,
        output throttle_in, pitch_in, roll_in, yaw_in,
        input  ready
    );
    modport sink (
        input  valid, link_quality, link_valid, elapsed_us,
        input  throttle_in, pitch_in, roll_in, yaw_in,
        output ready
    );
endinterface

>>> sv/lqfs_out_if.sv
`timescale 1ns / 1ps
// Output channel: scaled stick beat with failsafe status.
interface lqfs_out_if #(
    parameter int AXIS_WIDTH = 16
);
    logic                               valid;
    logic                               ready;
    logic [AXIS_WIDTH-2:0]              throttle_out;
    logic signed [AXIS_WIDTH-1:0]       pitch_out;
    logic signed [AXIS_WIDTH-1:0]       roll_out;
    logic signed [AXIS_WIDTH-1:0]       yaw_out;
    logic [lqfs_pkg::SCL_W-1:0]         input_scale;
    logic                               failsafe_active;

    modport source (
        output valid, throttle_out, pitch_out, roll_out, yaw_out,
        output input_scale, failsafe_active,
        input  ready
    );
    modport sink (
        input  valid, throttle_out, pitch_out, roll_out, yaw_out,
        input  input_scale, failsafe_active,
        output ready
    );
endinterface

>>> sv/lqfs_cfg_regs.sv
`timescale 1ns / 1ps
// APB configuration register file.
module lqfs_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lqfs_pkg::APB_AW-1:0] paddr,
    input  logic [lqfs_pkg::APB_DW-1:0] pwdata,
    output logic [lqfs_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output lqfs_pkg::t_cfg              o_cfg
);

    lqfs_pkg::t_cfg    r_cfg;
    lqfs_pkg::t_reg_idx w_idx;

    assign w_idx  = lqfs_pkg::t_reg_idx'(paddr[lqfs_pkg::APB_AW-1:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.failsafe_level <= 10'd200;
            r_cfg.enter_delay_us <= 26'd1000000;
            r_cfg.recover_level  <= 10'd400;
            r_cfg.degraded_level <= 10'd700;
            r_cfg.critical_level <= 10'd350;
            r_cfg.minimum_scale  <= 16'd8192;
            r_cfg.critical_scale <= 16'd19661;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_idx)
                lqfs_pkg::REG_FAILSAFE_LEVEL: begin
                    r_cfg.failsafe_level <= pwdata[lqfs_pkg::LQ_W-1:0];
                end
                lqfs_pkg::REG_ENTER_DELAY: begin
                    r_cfg.enter_delay_us <= pwdata[lqfs_pkg::TMR_W-1:0];
                end
                lqfs_pkg::REG_RECOVER_LEVEL: begin
                    r_cfg.recover_level <= pwdata[lqfs_pkg::LQ_W-1:0];
                end
                lqfs_pkg::REG_DEGRADED_LEVEL: begin
                    r_cfg.degraded_level <= pwdata[lqfs_pkg::LQ_W-1:0];
                end
                lqfs_pkg::REG_CRITICAL_LEVEL: begin
                    r_cfg.critical_level <= pwdata[lqfs_pkg::LQ_W-1:0];
                end
                lqfs_pkg::REG_MINIMUM_SCALE: begin
                    r_cfg.minimum_scale <= pwdata[lqfs_pkg::SCL_W-1:0];
                end
                lqfs_pkg::REG_CRITICAL_SCALE: begin
                    r_cfg.critical_scale <= pwdata[lqfs_pkg::SCL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            lqfs_pkg::REG_FAILSAFE_LEVEL: prdata = lqfs_pkg::APB_DW'(r_cfg.failsafe_level);
            lqfs_pkg::REG_ENTER_DELAY:    prdata = lqfs_pkg::APB_DW'(r_cfg.enter_delay_us);
            lqfs_pkg::REG_RECOVER_LEVEL:  prdata = lqfs_pkg::APB_DW'(r_cfg.recover_level);
            lqfs_pkg::REG_DEGRADED_LEVEL: prdata = lqfs_pkg::APB_DW'(r_cfg.degraded_level);
            lqfs_pkg::REG_CRITICAL_LEVEL: prdata = lqfs_pkg::APB_DW'(r_cfg.critical_level);
            lqfs_pkg::REG_MINIMUM_SCALE:  prdata = lqfs_pkg::APB_DW'(r_cfg.minimum_scale);
            lqfs_pkg::REG_CRITICAL_SCALE: prdata = lqfs_pkg::APB_DW'(r_cfg.critical_scale);
            default:                      prdata = '0;
        endcase
    end

endmodule

>>> sv/lqfs_mdu.sv
`timescale 1ns / 1ps
// Shared multiply and bit-serial restoring divide unit.
module lqfs_mdu #(
    parameter int A_W = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  lqfs_pkg::t_mdu_req                    i_req,
    input  logic signed [A_W-1:0]                 i_mul_a,
    input  logic signed [lqfs_pkg::B_W-1:0]       i_mul_b,
    input  logic [lqfs_pkg::DIV_W-1:0]            i_num,
    input  logic [lqfs_pkg::DEN_W-1:0]            i_den,
    output logic signed [A_W+lqfs_pkg::B_W-1:0]   o_prod,
    output logic [lqfs_pkg::DIV_W-1:0]            o_quo,
    output lqfs_pkg::t_mdu_sts                    o_sts
);

    localparam int P_W   = A_W + lqfs_pkg::B_W;
    localparam int CNT_W = $clog2(lqfs_pkg::DIV_W);

    logic signed [P_W-1:0]              r_prod;
    logic [lqfs_pkg::DIV_W-1:0]         r_quo;
    logic [lqfs_pkg::DEN_W-1:0]         r_rem;
    logic [lqfs_pkg::DEN_W-1:0]         r_den;
    logic [CNT_W-1:0]                   r_cnt;
    logic                               r_busy;
    logic                               r_done;

    logic [lqfs_pkg::DEN_W:0]           n_rem_sh;
    logic [lqfs_pkg::DEN_W:0]           n_rem_sub;
    logic                               n_fit;

    assign n_rem_sh  = {r_rem, r_quo[lqfs_pkg::DIV_W-1]};
    assign n_fit     = (n_rem_sh >= {1'b0, r_den});
    assign n_rem_sub = n_rem_sh - {1'b0, r_den};

    assign o_prod      = r_prod;
    assign o_quo       = r_quo;
    assign o_sts.busy  = r_busy;
    assign o_sts.done  = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= '0;
                if (i_req.op == lqfs_pkg::MDU_MUL) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(lqfs_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            if (i_req.op == lqfs_pkg::MDU_MUL) begin
                r_prod <= i_mul_a * i_mul_b;
            end else begin
                r_quo <= i_num;
                r_rem <= '0;
                r_den <= i_den;
            end
        end else if (r_busy) begin
            r_rem <= n_fit ? n_rem_sub[lqfs_pkg::DEN_W-1:0] : n_rem_sh[lqfs_pkg::DEN_W-1:0];
            r_quo <= {r_quo[lqfs_pkg::DIV_W-2:0], n_fit};
        end
    end

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("mdu started while dividing");

    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start && i_req.op == lqfs_pkg::MDU_DIV |=> r_busy && !r_done)
        else $error("divide did not start");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> r_done)
        else $error("divide ended without done");

endmodule

>>> sv/link_quality_failsafe_scaler.sv
`timescale 1ns / 1ps
// Link quality failsafe and stick scaler top level.
// From input beat to result: in failsafe the timer step goes straight to the output register;
// at full scale the three axes are multiplied; a clamped segment first adds the segment setup,
// and an interpolated scale adds a multiply and the 25-step divide of the shared unit.
// A new beat is taken in idle, while the last result may still wait in the output register.
// Reset (synchronous, active low) clears the timer, failsafe flag and handshake; loads defaults.
module link_quality_failsafe_scaler #(
    parameter int AXIS_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lqfs_pkg::APB_AW-1:0] paddr,
    input  logic [lqfs_pkg::APB_DW-1:0] pwdata,
    output logic [lqfs_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    lqfs_in_if.sink                     i_in,
    lqfs_out_if.source                  o_out
);

    localparam int LQ_W  = lqfs_pkg::LQ_W;
    localparam int Q_W   = lqfs_pkg::Q_W;
    localparam int B_W   = lqfs_pkg::B_W;
    localparam int TMR_W = lqfs_pkg::TMR_W;
    localparam int THR_W = AXIS_WIDTH - 1;
    localparam int MA_W  = (AXIS_WIDTH > LQ_W + 2) ? AXIS_WIDTH : LQ_W + 2;
    localparam int P_W   = MA_W + B_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TIMER,
        S_SEG,
        S_FRAC,
        S_SMUL,
        S_SDIV,
        S_AXIS,
        S_AMUL,
        S_DONE
    } t_state;

    lqfs_pkg::t_cfg                 w_cfg;
    lqfs_pkg::t_mdu_req             w_req;
    lqfs_pkg::t_mdu_sts             w_sts;
    logic signed [MA_W-1:0]         w_mul_a;
    logic signed [B_W-1:0]          w_mul_b;
    logic [lqfs_pkg::DIV_W-1:0]     w_num;
    logic signed [P_W-1:0]          w_prod;
    logic [lqfs_pkg::DIV_W-1:0]     w_quo;

    t_state                         r_state;
    logic [TMR_W-1:0]               r_timer;
    logic                           r_fs;
    logic [LQ_W-1:0]                r_lq;
    logic [lqfs_pkg::EL_W-1:0]      r_elapsed;
    logic [THR_W-1:0]               r_throttle;
    logic signed [AXIS_WIDTH-1:0]   r_stick [3];
    logic signed [AXIS_WIDTH-1:0]   r_axres [3];
    logic signed [LQ_W:0]           r_n;
    logic signed [LQ_W:0]           r_d;
    logic signed [B_W-1:0]          r_o0;
    logic signed [B_W-1:0]          r_o1;
    logic                           r_dzero;
    logic                           r_qgeb;
    logic                           r_neg;
    logic [Q_W-1:0]                 r_scale;
    logic [1:0]                     r_ax_idx;
    logic                           r_out_valid;
    logic [THR_W-1:0]               r_out_thr;
    logic signed [AXIS_WIDTH-1:0]   r_out_pitch;
    logic signed [AXIS_WIDTH-1:0]   r_out_roll;
    logic signed [AXIS_WIDTH-1:0]   r_out_yaw;
    logic [lqfs_pkg::SCL_W-1:0]     r_out_scale;
    logic                           r_out_fs;

    logic [TMR_W:0]                 n_tsum;
    logic [TMR_W-1:0]               n_tsat;
    logic                           n_low;
    logic                           n_fs;
    logic                           n_seg_lo;
    logic [LQ_W-1:0]                n_a;
    logic [LQ_W-1:0]                n_b;
    logic [Q_W-1:0]                 n_min_cl;
    logic [Q_W-1:0]                 n_crit_cl;
    logic signed [LQ_W:0]           n_nraw;
    logic signed [LQ_W:0]           n_draw;
    logic                           n_frac_mul;
    logic signed [P_W-1:0]          n_mag;
    logic signed [P_W-1:0]          n_padj;
    logic signed [P_W-1:0]          n_psh;
    logic signed [B_W-1:0]          n_qext;
    logic signed [B_W-1:0]          n_sseg;

    lqfs_cfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lqfs_mdu #(
        .A_W (MA_W)
    ) u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_mul_a (w_mul_a),
        .i_mul_b (w_mul_b),
        .i_num   (w_num),
        .i_den   (r_d[lqfs_pkg::DEN_W-1:0]),
        .o_prod  (w_prod),
        .o_quo   (w_quo),
        .o_sts   (w_sts)
    );

    // timer and failsafe flag
    assign n_tsum = {1'b0, r_timer} + {{(TMR_W + 1 - lqfs_pkg::EL_W){1'b0}}, r_elapsed};
    assign n_tsat = n_tsum[TMR_W] ? lqfs_pkg::TIMER_MAX : n_tsum[TMR_W-1:0];
    assign n_low  = (r_lq <= w_cfg.failsafe_level);
    assign n_fs   = n_low ? (r_fs || (n_tsat >= w_cfg.enter_delay_us))
                          : (r_fs && (r_lq < w_cfg.recover_level));

    // segment selection
    assign n_min_cl  = (w_cfg.minimum_scale > lqfs_pkg::SCL_W'(lqfs_pkg::Q_ONE))
                     ? lqfs_pkg::Q_ONE : {1'b0, w_cfg.minimum_scale};
    assign n_crit_cl = (w_cfg.critical_scale > lqfs_pkg::SCL_W'(lqfs_pkg::Q_ONE))
                     ? lqfs_pkg::Q_ONE : {1'b0, w_cfg.critical_scale};
    assign n_seg_lo  = (r_lq <= w_cfg.critical_level);
    assign n_a       = n_seg_lo ? w_cfg.failsafe_level : w_cfg.critical_level;
    assign n_b       = n_seg_lo ? w_cfg.critical_level : w_cfg.degraded_level;
    assign n_nraw    = $signed({1'b0, r_lq}) - $signed({1'b0, n_a});
    assign n_draw    = $signed({1'b0, n_b}) - $signed({1'b0, n_a});

    assign n_frac_mul = !r_dzero && !(r_n[LQ_W] || (r_n == '0)) && (r_n < r_d);

    // shared unit operands
    assign w_mul_a = (r_state == S_FRAC) ? MA_W'(r_n) : MA_W'(r_stick[r_ax_idx]);
    assign w_mul_b = (r_state == S_FRAC) ? (r_o1 - r_o0) : $signed({1'b0, r_scale});
    assign n_mag   = w_prod[P_W-1] ? -w_prod : w_prod;
    assign w_num   = n_mag[lqfs_pkg::DIV_W-1:0];

    assign w_req.start = ((r_state == S_FRAC) && n_frac_mul)
                      || ((r_state == S_SMUL) && w_sts.done)
                      || (r_state == S_AXIS);
    assign w_req.op    = (r_state == S_SMUL) ? lqfs_pkg::MDU_DIV : lqfs_pkg::MDU_MUL;

    // round toward zero on the product with the Q2.15 scale
    assign n_padj = w_prod + (w_prod[P_W-1]
                  ? $signed({{(P_W - lqfs_pkg::Q_FRAC){1'b0}}, {lqfs_pkg::Q_FRAC{1'b1}}})
                  : $signed({P_W{1'b0}}));
    assign n_psh  = n_padj >>> lqfs_pkg::Q_FRAC;

    assign n_qext = $signed({1'b0, w_quo[Q_W-1:0]});
    assign n_sseg = r_o0 + (r_neg ? -n_qext : n_qext);

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_out_valid;
    assign o_out.throttle_out    = r_out_thr;
    assign o_out.pitch_out       = r_out_pitch;
    assign o_out.roll_out        = r_out_roll;
    assign o_out.yaw_out         = r_out_yaw;
    assign o_out.input_scale     = r_out_scale;
    assign o_out.failsafe_active = r_out_fs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_timer     <= '0;
            r_fs        <= 1'b0;
            r_out_valid <= 1'b0;
            r_ax_idx    <= '0;
        end else begin
            if (r_out_valid && o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_lq       <= i_in.link_valid ? i_in.link_quality : lqfs_pkg::FULL_QUALITY;
                        r_elapsed  <= i_in.elapsed_us;
                        r_throttle <= i_in.throttle_in;
                        r_stick[0] <= i_in.pitch_in;
                        r_stick[1] <= i_in.roll_in;
                        r_stick[2] <= i_in.yaw_in;
                        r_state    <= S_TIMER;
                    end
                end
                S_TIMER: begin
                    r_timer  <= n_low ? n_tsat : '0;
                    r_fs     <= n_fs;
                    r_ax_idx <= '0;
                    if (n_fs) begin
                        r_state <= S_DONE;
                    end else if (r_lq >= w_cfg.degraded_level) begin
                        r_scale <= lqfs_pkg::Q_ONE;
                        r_state <= S_AXIS;
                    end else begin
                        r_state <= S_SEG;
                    end
                end
                S_SEG: begin
                    r_n     <= n_draw[LQ_W] ? -n_nraw : n_nraw;
                    r_d     <= n_draw[LQ_W] ? -n_draw : n_draw;
                    r_dzero <= (n_draw == '0);
                    r_qgeb  <= (r_lq >= n_b);
                    r_o0    <= $signed({1'b0, n_seg_lo ? n_min_cl : n_crit_cl});
                    r_o1    <= $signed({1'b0, n_seg_lo ? n_crit_cl : lqfs_pkg::Q_ONE});
                    r_state <= S_FRAC;
                end
                S_FRAC: begin
                    if (n_frac_mul) begin
                        r_state <= S_SMUL;
                    end else begin
                        if (r_dzero) begin
                            r_scale <= r_qgeb ? r_o1[Q_W-1:0] : r_o0[Q_W-1:0];
                        end else if (r_n[LQ_W] || (r_n == '0)) begin
                            r_scale <= r_o0[Q_W-1:0];
                        end else begin
                            r_scale <= r_o1[Q_W-1:0];
                        end
                        r_state <= S_AXIS;
                    end
                end
                S_SMUL: begin
                    if (w_sts.done) begin
                        r_neg   <= w_prod[P_W-1];
                        r_state <= S_SDIV;
                    end
                end
                S_SDIV: begin
                    if (w_sts.done) begin
                        r_scale <= n_sseg[Q_W-1:0];
                        r_state <= S_AXIS;
                    end
                end
                S_AXIS: begin
                    r_state <= S_AMUL;
                end
                S_AMUL: begin
                    if (w_sts.done) begin
                        r_axres[r_ax_idx] <= n_psh[AXIS_WIDTH-1:0];
                        if (r_ax_idx == 2'd2) begin
                            r_state <= S_DONE;
                        end else begin
                            r_ax_idx <= r_ax_idx + 1'b1;
                            r_state  <= S_AXIS;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_fs    <= r_fs;
                        if (r_fs) begin
                            r_out_thr   <= '0;
                            r_out_pitch <= '0;
                            r_out_roll  <= '0;
                            r_out_yaw   <= '0;
                            r_out_scale <= '0;
                        end else begin
                            r_out_thr   <= r_throttle;
                            r_out_pitch <= r_axres[0];
                            r_out_roll  <= r_axres[1];
                            r_out_yaw   <= r_axres[2];
                            r_out_scale <= r_scale[lqfs_pkg::SCL_W-1:0];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.done |-> (r_state == S_SMUL || r_state == S_SDIV || r_state == S_AMUL))
        else $error("shared unit result outside a wait state");

    a_fs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_fs) |-> (r_timer >= w_cfg.enter_delay_us))
        else $error("failsafe latched before entry delay");

    a_fs_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_fs |-> (r_out_scale == '0) && (r_out_pitch == '0)
                                    && (r_out_thr == '0))
        else $error("nonzero output in failsafe");

    a_idle_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_sts.busy)
        else $error("divide running while idle");

endmodule
